// File: src/deq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package deq_pkg;

    localparam int CMD_W    = 3;
    localparam int WORD_W   = 32;
    localparam int COUNT_W  = 5;
    localparam int STATUS_W = 2;

    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLEAR      = 3'd4;
    localparam logic [CMD_W-1:0] CMD_PEEK       = 3'd5;

    localparam logic [STATUS_W-1:0] ST_DONE       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_PUSH_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_POP_EMPTY  = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [WORD_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic [WORD_W-1:0]   front_word;
        logic [WORD_W-1:0]   back_word;
        logic [COUNT_W-1:0]  item_count;
        logic                is_empty;
        logic                is_full;
        logic [STATUS_W-1:0] status;
    } t_out_item;

    // controller -> datapath step strobes
    typedef struct packed {
        logic capture;
        logic execute;
        logic read;
    } t_dp_cmd;

endpackage

`default_nettype wire

// File: src/deq_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module deq_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_stall,
    output logic                 o_out_valid,
    input  wire logic            i_out_stall,
    output deq_pkg::t_dp_cmd     o_cmd
);
    import deq_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_READ = 2'd2;
    localparam logic [1:0] S_SEND = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_stall  = 1'b1;
        o_out_valid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.execute = 1'b1;
                n_state       = S_READ;
            end
            S_READ: begin
                o_cmd.read = 1'b1;
                n_state    = S_SEND;
            end
            S_SEND: begin
                o_out_valid = 1'b1;
                if (!i_out_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// File: src/deq_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module deq_dp #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire deq_pkg::t_dp_cmd  i_cmd,
    input  wire deq_pkg::t_in_item i_item,
    output deq_pkg::t_out_item     o_item
);
    import deq_pkg::*;

    localparam int AW   = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int SUMW = CW + 1;
    localparam int MW   = (DATA_WIDTH < WORD_W) ? DATA_WIDTH : WORD_W;

    localparam logic [AW-1:0]   LAST_POS   = AW'(DEPTH - 1);
    localparam logic [CW-1:0]   FULL_COUNT = CW'(DEPTH);
    localparam logic [SUMW-1:0] DEPTH_SUM  = SUMW'(DEPTH);

    logic [MW-1:0] r_mem [DEPTH];

    logic [CMD_W-1:0]    r_command;
    logic [MW-1:0]       r_word;
    logic [AW-1:0]       r_front;
    logic [CW-1:0]       r_count;
    logic [STATUS_W-1:0] r_status;
    logic [MW-1:0]       r_front_rd;
    logic [MW-1:0]       r_back_rd;

    logic [AW-1:0]       n_front;
    logic [CW-1:0]       n_count;
    logic [STATUS_W-1:0] n_status;
    logic                wr_en;
    logic [AW-1:0]       wr_addr;

    logic                full;
    logic                empty;
    logic [AW-1:0]       front_dec;
    logic [AW-1:0]       front_inc;
    logic [SUMW-1:0]     tail_sum;
    logic [AW-1:0]       tail_addr;
    logic [SUMW-1:0]     back_sum;
    logic [AW-1:0]       back_addr;

    assign full      = (r_count == FULL_COUNT);
    assign empty     = (r_count == '0);
    assign front_dec = (r_front == '0) ? LAST_POS : r_front - AW'(1);
    assign front_inc = (r_front == LAST_POS) ? '0 : r_front + AW'(1);

    // slot just past the back, valid while not full
    assign tail_sum  = SUMW'(r_front) + SUMW'(r_count);
    assign tail_addr = (tail_sum >= DEPTH_SUM) ? AW'(tail_sum - DEPTH_SUM) : AW'(tail_sum);

    // back word slot, only used when the queue holds a word
    assign back_sum  = SUMW'(r_front) + SUMW'(r_count) - SUMW'(1);
    assign back_addr = (back_sum >= DEPTH_SUM) ? AW'(back_sum - DEPTH_SUM) : AW'(back_sum);

    always_comb begin
        n_front  = r_front;
        n_count  = r_count;
        n_status = ST_DONE;
        wr_en    = 1'b0;
        wr_addr  = tail_addr;
        case (r_command)
            CMD_PUSH_FRONT: begin
                if (full) begin
                    n_status = ST_PUSH_FULL;
                end else begin
                    n_front = front_dec;
                    n_count = r_count + CW'(1);
                    wr_en   = 1'b1;
                    wr_addr = front_dec;
                end
            end
            CMD_PUSH_BACK: begin
                if (full) begin
                    n_status = ST_PUSH_FULL;
                end else begin
                    n_count = r_count + CW'(1);
                    wr_en   = 1'b1;
                end
            end
            CMD_POP_FRONT: begin
                if (empty) begin
                    n_status = ST_POP_EMPTY;
                end else begin
                    n_front = front_inc;
                    n_count = r_count - CW'(1);
                end
            end
            CMD_POP_BACK: begin
                if (empty) begin
                    n_status = ST_POP_EMPTY;
                end else begin
                    n_count = r_count - CW'(1);
                end
            end
            CMD_CLEAR: begin
                n_front = '0;
                n_count = '0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front  <= '0;
            r_count  <= '0;
        end else if (i_cmd.execute) begin
            r_front  <= n_front;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_command <= i_item.command;
            r_word    <= MW'(i_item.value);
        end
        if (i_cmd.execute) begin
            r_status <= n_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.execute && wr_en) begin
            r_mem[wr_addr] <= r_word;
        end
        if (i_cmd.read && !empty) begin
            r_front_rd <= r_mem[r_front];
            r_back_rd  <= r_mem[back_addr];
        end
    end

    always_comb begin
        o_item.front_word = empty ? '0 : WORD_W'(r_front_rd);
        o_item.back_word  = empty ? '0 : WORD_W'(r_back_rd);
        o_item.item_count = COUNT_W'(r_count);
        o_item.is_empty   = empty;
        o_item.is_full    = full;
        o_item.status     = r_status;
    end

endmodule

`default_nettype wire

// File: src/double_ended_queue.sv
// Bounded double-ended queue over a DEPTH-slot ring store.
// Input channel (i_in_valid / o_in_stall / i_in_data): one transaction is one
//   command (push front, push back, pop front, pop back, clear, peek) plus a
//   data word used by the pushes only. Codes 6 and 7 act as peek.
// Output channel (o_out_valid / i_out_stall / o_out_data): exactly one
//   transaction per command, carrying the front and back words after the
//   command (zero when empty), the word count, empty/full flags and a status:
//   done, push dropped because full, or pop ignored because empty.
// Timing: a command is taken in the idle state, applied to the pointers and
//   the store in the next cycle, the store is read at the front and back slots
//   in the cycle after that, and the result is offered in the send state that
//   follows. One command is in flight at a time, so the next command waits
//   for the result transaction; the store's registered read port sets the
//   read step.
// Stall: while the result is stalled it holds steady and o_in_stall stays
//   high; the next command is taken once the result transaction completes.
// Reset (synchronous, active low) empties the queue and returns to idle; the
//   slot contents are not cleared, as only slots holding words are read.
`timescale 1ns / 1ps
`default_nettype none

module double_ended_queue #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire deq_pkg::t_in_item  i_in_data,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output deq_pkg::t_out_item      o_out_data
);
    import deq_pkg::*;

    // step strobes from the sequencer to the pointer/store datapath
    t_dp_cmd dp_cmd;

    deq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (dp_cmd)
    );

    // holds front pointer, count, status and the ring store; its outputs
    // are stable from the read step until the next command is captured
    deq_dp #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (dp_cmd),
        .i_item  (i_in_data),
        .o_item  (o_out_data)
    );

endmodule

`default_nettype wire
